// ===== rtl/bce_pkg.sv =====
// ----------------------------------------------------------------------------
// bce_pkg
// Shared types and constants for the backtracking choice enumerator: stack
// sizes, operation and status codes, the stack entry layout and the records
// passed between the sequencer and the top level.
// ----------------------------------------------------------------------------
package bce_pkg;

  // Stack geometry and field widths.
  localparam int STACK_DEPTH = 64;
  localparam int MAX_ALT     = 256;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int CEIL_W      = 9;
  localparam int CHOICE_W    = 8;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;

  // Operation codes carried with each input transfer.
  typedef enum logic [OP_W-1:0] {
    OP_CHOOSE = 2'd0,
    OP_SKIP   = 2'd1,
    OP_REPEAT = 2'd2,
    OP_RESET  = 2'd3
  } op_e;

  // Status codes returned with each result.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_CEIL = 2'd2,
    ST_NO_POINT = 2'd3
  } status_e;

  // One choice point as held in the stack memory.
  typedef struct packed {
    logic [CEIL_W-1:0]   ceiling;
    logic [CHOICE_W-1:0] choice;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Result of one operation.
  typedef struct packed {
    logic [CHOICE_W-1:0] choice;
    logic                more_runs;
    status_e             status;
  } result_t;

  // Access request from the sequencer to the stack memory.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

// ===== rtl/backtracking_choice_enumerator_core.sv =====
// A result is offered from the evaluate state that follows the input transfer
// for choose, skip rest and reset, and passes through the output register;
// repeat first walks back through every point that wraps around, up to the
// number of points. A new operation is taken only once the last result has
// entered the output register; the memory read precedes evaluate and write-back.
// Reset clears the position and point count at once; memory contents stay.
// ----------------------------------------------------------------------------
// backtracking_choice_enumerator_core
// Exhaustive choice enumerator over a stack of choice points held in one
// memory, with a registered result stage toward the output stream.
// ----------------------------------------------------------------------------
module backtracking_choice_enumerator_core (
  input  logic        clk,
  input  logic        rst,
  // Operation stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [1:0] op, [10:2] ceiling, [15:11] zero
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [7:0] choice, [8] more_runs, [10:9] status,
                                 // [15:11] zero
);

  bce_pkg::mem_req_t mem_req;
  bce_pkg::entry_t   mem_rdata;
  bce_pkg::result_t  res;
  bce_pkg::result_t  out_r;
  logic              res_valid;
  logic              res_ready;

  // Stack memory: one entry per choice point.
  bce_ram #(
    .WIDTH (bce_pkg::ENTRY_W),
    .DEPTH (bce_pkg::STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  // Operation sequencer.
  bce_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_op      (bce_pkg::op_e'(s_tdata[1:0])),
    .in_ceiling (s_tdata[10:2]),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .mem_req    (mem_req),
    .mem_rdata  (mem_rdata)
  );

  // Output register: loads when empty or when its transfer completes.
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign m_tdata = {5'd0, out_r.status, out_r.more_runs, out_r.choice};

endmodule

// ===== rtl/bce_ram.sv =====
// ----------------------------------------------------------------------------
// bce_ram
// Generic single-clock RAM with one write port and one read port. The read
// data is registered and holds while the read enable is low.
// ----------------------------------------------------------------------------
module bce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/bce_engine.sv =====
// ----------------------------------------------------------------------------
// bce_engine
// Sequencer for the choice stack. It keeps the position and point count,
// issues the memory read for an operation in the cycle the input transfer is
// taken, and evaluates and writes back once the entry arrives. Repeat walks
// back one entry per cycle until a point can be advanced or none is left.
// ----------------------------------------------------------------------------
module bce_engine (
  input  logic                          clk,
  input  logic                          rst,
  // Operation input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bce_pkg::op_e                  in_op,
  input  logic [bce_pkg::CEIL_W-1:0]    in_ceiling,
  // Result output
  output logic                          res_valid,
  input  logic                          res_ready,
  output bce_pkg::result_t              res,
  // Stack memory
  output bce_pkg::mem_req_t             mem_req,
  input  bce_pkg::entry_t               mem_rdata
);

  typedef enum logic {
    S_IDLE,
    S_EVAL
  } state_t;

  state_t                         state, state_next;
  bce_pkg::op_e                   op_r;
  logic [bce_pkg::CEIL_W-1:0]     ceil_r;
  // Position plus one: zero means no current point.
  logic [bce_pkg::CNT_W-1:0]      pos1, pos1_next;
  logic [bce_pkg::CNT_W-1:0]      count, count_next;
  // Walk index plus one for repeat: zero means the walk ran off the bottom.
  logic [bce_pkg::CNT_W-1:0]      walk, walk_next;
  logic [bce_pkg::CNT_W-1:0]      walk_init;
  logic [bce_pkg::CNT_W-1:0]      walk_m1;
  logic [bce_pkg::CNT_W-1:0]      pos1_m1;
  logic [bce_pkg::CEIL_W-1:0]     bumped;
  logic                           found;
  logic                           in_fire;
  logic                           bad_ceil;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign walk_init = (pos1 < count) ? pos1 : count;
  assign walk_m1   = walk - bce_pkg::CNT_W'(1);
  assign pos1_m1   = pos1 - bce_pkg::CNT_W'(1);
  assign bumped    = {1'b0, mem_rdata.choice} + bce_pkg::CEIL_W'(1);
  assign found     = (bumped < mem_rdata.ceiling);
  assign bad_ceil  = (ceil_r == '0) || (ceil_r > bce_pkg::CEIL_W'(bce_pkg::MAX_ALT));

  // Next-state, result and memory access logic.
  always_comb begin
    state_next    = state;
    pos1_next     = pos1;
    count_next    = count;
    walk_next     = walk;
    res_valid     = 1'b0;
    res.choice    = '0;
    res.more_runs = 1'b0;
    res.status    = bce_pkg::ST_OK;
    mem_req.we    = 1'b0;
    mem_req.waddr = '0;
    mem_req.wdata = '0;
    mem_req.re    = 1'b0;
    mem_req.raddr = '0;

    unique case (state)
      S_IDLE: begin
        // Fetch the entry the operation will need as the transfer is taken.
        if (in_fire) begin
          state_next = S_EVAL;
          unique case (in_op)
            bce_pkg::OP_CHOOSE: begin
              mem_req.re    = 1'b1;
              mem_req.raddr = pos1[bce_pkg::ADDR_W-1:0];
            end
            bce_pkg::OP_SKIP: begin
              mem_req.re    = 1'b1;
              mem_req.raddr = pos1_m1[bce_pkg::ADDR_W-1:0];
            end
            bce_pkg::OP_REPEAT: begin
              mem_req.re    = 1'b1;
              mem_req.raddr = bce_pkg::ADDR_W'(walk_init - bce_pkg::CNT_W'(1));
              walk_next     = walk_init;
            end
            default: begin
              mem_req.re = 1'b0;
            end
          endcase
        end
      end

      S_EVAL: begin
        unique case (op_r)
          bce_pkg::OP_CHOOSE: begin
            res_valid = 1'b1;
            if (res_ready) begin
              state_next = S_IDLE;
            end
            if (bad_ceil) begin
              res.status = bce_pkg::ST_BAD_CEIL;
            end else if (ceil_r == bce_pkg::CEIL_W'(1)) begin
              res.status = bce_pkg::ST_OK;
            end else if (pos1 < count) begin
              // Replay of a point already on the stack.
              res.choice = mem_rdata.choice;
              if (res_ready) begin
                pos1_next = pos1 + bce_pkg::CNT_W'(1);
              end
            end else if (count >= bce_pkg::CNT_W'(bce_pkg::STACK_DEPTH)) begin
              res.status = bce_pkg::ST_FULL;
            end else if (res_ready) begin
              // Push a new point with value zero.
              mem_req.we            = 1'b1;
              mem_req.waddr         = count[bce_pkg::ADDR_W-1:0];
              mem_req.wdata.ceiling = ceil_r;
              mem_req.wdata.choice  = '0;
              pos1_next             = count + bce_pkg::CNT_W'(1);
              count_next            = count + bce_pkg::CNT_W'(1);
            end
          end

          bce_pkg::OP_SKIP: begin
            res_valid = 1'b1;
            if (res_ready) begin
              state_next = S_IDLE;
            end
            if (pos1 == '0) begin
              res.status = bce_pkg::ST_NO_POINT;
            end else if (res_ready) begin
              // Stored ceilings are at least two, so the last value fits.
              mem_req.we            = 1'b1;
              mem_req.waddr         = pos1_m1[bce_pkg::ADDR_W-1:0];
              mem_req.wdata.ceiling = mem_rdata.ceiling;
              mem_req.wdata.choice  = bce_pkg::CHOICE_W'(mem_rdata.ceiling
                                      - bce_pkg::CEIL_W'(1));
            end
          end

          bce_pkg::OP_REPEAT: begin
            if (walk == '0) begin
              // Every point wrapped: all runs explored.
              res_valid = 1'b1;
              if (res_ready) begin
                state_next = S_IDLE;
                pos1_next  = '0;
                count_next = '0;
              end
            end else if (found) begin
              // Advance this point and cut the stack above it.
              res_valid     = 1'b1;
              res.more_runs = 1'b1;
              if (res_ready) begin
                state_next            = S_IDLE;
                mem_req.we            = 1'b1;
                mem_req.waddr         = walk_m1[bce_pkg::ADDR_W-1:0];
                mem_req.wdata.ceiling = mem_rdata.ceiling;
                mem_req.wdata.choice  = bumped[bce_pkg::CHOICE_W-1:0];
                pos1_next             = '0;
                count_next            = walk;
              end
            end else begin
              // This point wraps; it lies above the new top, so no write-back.
              walk_next = walk_m1;
              if (walk_m1 != '0) begin
                mem_req.re    = 1'b1;
                mem_req.raddr = bce_pkg::ADDR_W'(walk_m1 - bce_pkg::CNT_W'(1));
              end
            end
          end

          default: begin
            // Reset operation empties the stack.
            res_valid = 1'b1;
            if (res_ready) begin
              state_next = S_IDLE;
              pos1_next  = '0;
              count_next = '0;
            end
          end
        endcase
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State, stack pointers and captured operation.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pos1  <= '0;
      count <= '0;
      walk  <= '0;
    end else begin
      state <= state_next;
      pos1  <= pos1_next;
      count <= count_next;
      walk  <= walk_next;
    end
    if (in_fire) begin
      op_r   <= in_op;
      ceil_r <= in_ceiling;
    end
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the backtracking choice enumerator. A short table
// of directed operations covers the no-point and bad-ceiling codes and the
// field extremes. It is followed by random enumeration sessions: runs of
// chooses closed by a repeat, with skips, resets and noise mixed in. Every
// result transfer is checked against a typed row or an in-bench model of the choice stack.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int ITEM_TARGET = 1650;
  localparam int IDLE_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 100;
  localparam int N_DIRECTED  = 25;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  // One directed row; typed rows carry their expected result.
  typedef struct packed {
    bce_pkg::op_e                 op;
    logic [bce_pkg::CEIL_W-1:0]   ceil;
    logic                         typed;
    logic [bce_pkg::CHOICE_W-1:0] choice;
    logic                         more_runs;
    bce_pkg::status_e             status;
  } directed_row_t;

  localparam directed_row_t DIRECTED [0:N_DIRECTED-1] = '{
    '{bce_pkg::OP_SKIP,   9'd0,   1'b1, 8'd0, 1'b0, bce_pkg::ST_NO_POINT},
    '{bce_pkg::OP_REPEAT, 9'd0,   1'b1, 8'd0, 1'b0, bce_pkg::ST_OK},
    '{bce_pkg::OP_CHOOSE, 9'd0,   1'b1, 8'd0, 1'b0, bce_pkg::ST_BAD_CEIL},
    '{bce_pkg::OP_CHOOSE, 9'd257, 1'b1, 8'd0, 1'b0, bce_pkg::ST_BAD_CEIL},
    '{bce_pkg::OP_CHOOSE, 9'd511, 1'b1, 8'd0, 1'b0, bce_pkg::ST_BAD_CEIL},
    '{bce_pkg::OP_CHOOSE, 9'd1,   1'b1, 8'd0, 1'b0, bce_pkg::ST_OK},
    '{bce_pkg::OP_CHOOSE, 9'd256, 1'b1, 8'd0, 1'b0, bce_pkg::ST_OK},
    '{bce_pkg::OP_CHOOSE, 9'd3,   1'b1, 8'd0, 1'b0, bce_pkg::ST_OK},
    '{bce_pkg::OP_SKIP,   9'd0,   1'b1, 8'd0, 1'b0, bce_pkg::ST_OK},
    '{bce_pkg::OP_REPEAT, 9'd0,   1'b0, 8'd0, 1'b0, bce_pkg::ST_OK},
    '{bce_pkg::OP_CHOOSE, 9'd256, 1'b0, 8'd0, 1'b0, bce_pkg::ST_OK},
    '{bce_pkg::OP_CHOOSE, 9'd3,   1'b0, 8'd0, 1'b0, bce_pkg::ST_OK},
    '{bce_pkg::OP_CHOOSE, 9'd2,   1'b0, 8'd0, 1'b0, bce_pkg::ST_OK},
    '{bce_pkg::OP_SKIP,   9'd511, 1'b0, 8'd0, 1'b0, bce_pkg::ST_OK},
    '{bce_pkg::OP_REPEAT, 9'd0,   1'b0, 8'd0, 1'b0, bce_pkg::ST_OK},
    '{bce_pkg::OP_CHOOSE, 9'd256, 1'b0, 8'd0, 1'b0, bce_pkg::ST_OK},
    '{bce_pkg::OP_SKIP,   9'd0,   1'b0, 8'd0, 1'b0, bce_pkg::ST_OK},
    '{bce_pkg::OP_REPEAT, 9'd0,   1'b0, 8'd0, 1'b0, bce_pkg::ST_OK},
    '{bce_pkg::OP_SKIP,   9'd0,   1'b1, 8'd0, 1'b0, bce_pkg::ST_NO_POINT},
    '{bce_pkg::OP_CHOOSE, 9'd2,   1'b1, 8'd0, 1'b0, bce_pkg::ST_OK},
    '{bce_pkg::OP_RESET,  9'd511, 1'b1, 8'd0, 1'b0, bce_pkg::ST_OK},
    '{bce_pkg::OP_SKIP,   9'd0,   1'b1, 8'd0, 1'b0, bce_pkg::ST_NO_POINT},
    '{bce_pkg::OP_CHOOSE, 9'd2,   1'b1, 8'd0, 1'b0, bce_pkg::ST_OK},
    '{bce_pkg::OP_CHOOSE, 9'd2,   1'b1, 8'd0, 1'b0, bce_pkg::ST_OK},
    '{bce_pkg::OP_REPEAT, 9'd0,   1'b0, 8'd0, 1'b0, bce_pkg::ST_OK}
  };

  // Model of the choice stack.
  int cur_pos;
  int pt_count;
  int ceil_mem [0:bce_pkg::STACK_DEPTH-1];
  int val_mem  [0:bce_pkg::STACK_DEPTH-1];
  bit more_left;

  bce_pkg::result_t pending_results [$];
  int               items_sent = 0;
  int               fail_count = 0;
  int               idle_cycles = 0;
  bit               calm;

  backtracking_choice_enumerator_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  // Both sides run without idling over this stretch of the run.
  assign calm = (items_sent >= 700) && (items_sent < 950);

  // Applies one operation to the model stack and returns its result.
  function automatic bce_pkg::result_t apply_op(bce_pkg::op_e op,
                                                logic [bce_pkg::CEIL_W-1:0] ceil);
    bce_pkg::result_t res;
    int nxt;
    int p;
    res = '{choice: '0, more_runs: 1'b0, status: bce_pkg::ST_OK};
    case (op)
      bce_pkg::OP_CHOOSE: begin
        if (ceil == 0 || ceil > bce_pkg::MAX_ALT) begin
          res.status = bce_pkg::ST_BAD_CEIL;
        end else if (ceil > 1) begin
          nxt = cur_pos + 1;
          if (nxt < pt_count) begin
            cur_pos = nxt;
            res.choice = val_mem[nxt][bce_pkg::CHOICE_W-1:0];
          end else if (pt_count >= bce_pkg::STACK_DEPTH) begin
            res.status = bce_pkg::ST_FULL;
          end else begin
            ceil_mem[pt_count] = ceil;
            val_mem[pt_count] = 0;
            cur_pos = pt_count;
            pt_count++;
          end
        end
      end
      bce_pkg::OP_SKIP: begin
        if (cur_pos < 0 || cur_pos >= pt_count) begin
          res.status = bce_pkg::ST_NO_POINT;
        end else if (ceil_mem[cur_pos] > 1) begin
          val_mem[cur_pos] = ceil_mem[cur_pos] - 1;
        end
      end
      bce_pkg::OP_REPEAT: begin
        // Odometer step from the current point back toward the bottom.
        p = cur_pos;
        if (p >= pt_count) p = pt_count - 1;
        while (p >= 0) begin
          val_mem[p] = val_mem[p] + 1;
          if (val_mem[p] < ceil_mem[p]) break;
          p--;
        end
        if (p < 0) begin
          pt_count = 0;
        end else begin
          pt_count = p + 1;
          res.more_runs = 1'b1;
        end
        cur_pos = -1;
      end
      default: begin
        cur_pos = -1;
        pt_count = 0;
      end
    endcase
    more_left = res.more_runs;
    return res;
  endfunction

  // Drives one operation and records its expected result at the transfer.
  task automatic send_op(bce_pkg::op_e op, logic [bce_pkg::CEIL_W-1:0] ceil,
                         bit typed = 1'b0, bce_pkg::result_t typed_res = '0);
    bce_pkg::result_t predicted;
    if (!calm) begin
      while ($urandom_range(99) < 14) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'b0, ceil, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = apply_op(op, ceil);
    if (typed) predicted = typed_res;
    pending_results = {pending_results, predicted};
    items_sent++;
  endtask

  task automatic send_noise();
    send_op(bce_pkg::op_e'($urandom_range(3)), bce_pkg::CEIL_W'($urandom_range(511)));
  endtask

  // One enumeration session: fixed ceilings per depth, runs closed by repeat.
  task automatic run_session();
    int depth;
    int runs;
    int pick;
    int ceil_at [0:69];
    pick = $urandom_range(99);
    depth = (pick < 6) ? $urandom_range(62, 69) : $urandom_range(1, 6);
    runs = (pick < 6) ? $urandom_range(1, 3) : $urandom_range(1, 16);
    for (int i = 0; i < depth; i++) begin
      pick = $urandom_range(99);
      if (depth > 8) ceil_at[i] = 2;
      else if (pick < 70) ceil_at[i] = $urandom_range(1, 4);
      else if (pick < 80) ceil_at[i] = 1;
      else if (pick < 90) ceil_at[i] = $urandom_range(255, 256);
      else ceil_at[i] = $urandom_range(2, 256);
    end
    for (int r = 0; r < runs; r++) begin
      for (int i = 0; i < depth; i++) begin
        pick = $urandom_range(99);
        if (pick < 4) send_noise();
        send_op(bce_pkg::OP_CHOOSE, bce_pkg::CEIL_W'(ceil_at[i]));
        if (pick >= 90) send_op(bce_pkg::OP_SKIP, bce_pkg::CEIL_W'($urandom_range(511)));
      end
      send_op(bce_pkg::OP_REPEAT, bce_pkg::CEIL_W'($urandom_range(511)));
      if (!more_left) break;
    end
    if ($urandom_range(3) == 0) begin
      send_op(bce_pkg::OP_RESET, bce_pkg::CEIL_W'($urandom_range(511)));
    end
  endtask

  // Stimulus and end of run.
  initial begin
    bce_pkg::result_t typed_res;
    cur_pos = -1;
    pt_count = 0;
    more_left = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < N_DIRECTED; i++) begin
      typed_res.choice = DIRECTED[i].choice;
      typed_res.more_runs = DIRECTED[i].more_runs;
      typed_res.status = DIRECTED[i].status;
      send_op(DIRECTED[i].op, DIRECTED[i].ceil, DIRECTED[i].typed, typed_res);
    end
    while (items_sent < ITEM_TARGET) run_session();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Result side: compare each transfer with the oldest expectation.
  always @(posedge clk) begin : result_check
    bce_pkg::result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with no expectation waiting: data %h", m_tdata);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (m_tdata[7:0] !== want.choice) begin
            $error("choice: expected %0d, actual %0d", want.choice, m_tdata[7:0]);
            fail_count++;
          end
          if (m_tdata[8] !== want.more_runs) begin
            $error("more_runs: expected %0d, actual %0d", want.more_runs, m_tdata[8]);
            fail_count++;
          end
          if (m_tdata[10:9] !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, m_tdata[10:9]);
            fail_count++;
          end
        end
      end
      m_tready <= calm || ($urandom_range(99) >= 14);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

endmodule
